// ===== hw/rtl/mh2_pkg.sv =====
// shared constants and helpers for the murmurhash2 engine
package mh2_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 3;

    localparam logic [WORD_W-1:0]  MIX_MUL     = 32'h5bd1e995;
    localparam int unsigned        MIX_SHIFT   = 24;
    localparam int unsigned        FIN_SHIFT_A = 13;
    localparam int unsigned        FIN_SHIFT_B = 15;
    localparam logic [WORD_W-1:0]  SEED_RESET  = 32'd97;
    localparam logic [COUNT_W-1:0] FULL_COUNT  = 3'd4;

    // keeps the valid low bytes of a tail word (counts 1..3, any other count gives zero)
    function automatic logic [WORD_W-1:0] tail_bytes(
        input logic [WORD_W-1:0]  word,
        input logic [COUNT_W-1:0] count
    );
        logic [WORD_W-1:0] mask;
        begin
            case (count)
                3'd1:    mask = 32'h0000_00ff;
                3'd2:    mask = 32'h0000_ffff;
                3'd3:    mask = 32'h00ff_ffff;
                default: mask = '0;
            endcase
            tail_bytes = word & mask;
        end
    endfunction

endpackage

// ===== hw/rtl/mh2_channels.sv =====
// valid/ready stream interfaces for the hash input and result channels
interface mh2_in_if;
    logic                          valid;
    logic                          ready;
    logic [mh2_pkg::WORD_W-1:0]    data_word;
    logic [mh2_pkg::COUNT_W-1:0]   byte_count;
    logic                          first_word;
    logic                          last_word;
    logic [mh2_pkg::WORD_W-1:0]    total_length;

    modport source (
        output valid, data_word, byte_count, first_word, last_word, total_length,
        input  ready
    );
    modport sink (
        input  valid, data_word, byte_count, first_word, last_word, total_length,
        output ready
    );
endinterface

interface mh2_out_if;
    logic                          valid;
    logic                          ready;
    logic [mh2_pkg::WORD_W-1:0]    hash_value;
    logic                          length_error;

    modport source (
        output valid, hash_value, length_error,
        input  ready
    );
    modport sink (
        input  valid, hash_value, length_error,
        output ready
    );
endinterface

// ===== hw/rtl/murmur2_hash_engine_top.sv =====
// streaming 32-bit murmurhash2 engine, top level
// usage:
//   in_ch carries one beat per message word: data_word (little-endian bytes),
//   byte_count, first_word, last_word and total_length (used on first beats).
//   a first beat restarts the hash at hash_seed xor total_length.
//   out_ch carries one beat per last input beat: hash_value and length_error.
//   a short byte_count on a non-last beat (or a count above four) drops the
//   message; its last beat returns hash_value 0 with length_error set.
//   cfg_wr_en/cfg_wr_data write hash_seed; write only while the block is idle.
// sequencing:
//   one multiplier is shared by all products, so in_ch.ready is low while a
//   beat is in work. a full word runs ST_K_XOR, ST_K_SAVE, ST_H_MIX (three
//   products), a 1..3 byte tail ST_TAIL; an empty tail or a dropped or skipped
//   beat needs no mixing. a last beat adds ST_FIN_MUL and ST_FIN_OUT (one more
//   product), a dropped one ST_ERR_OUT, before loading the output register.
// reset: hash_seed returns to 97, hash and error flag clear, no result pending
// stall: a result beat waits in the output register; the next input beat is
//   still taken, and the engine only holds if a new result is ready while the
//   previous one has not been taken yet.
module murmur2_hash_engine_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [mh2_pkg::WORD_W-1:0] cfg_wr_data,
    mh2_in_if.sink                     in_ch,
    mh2_out_if.source                  out_ch
);

    typedef enum logic [2:0] {
        ST_IDLE,     // waiting for an input beat
        ST_K_XOR,    // k = w*M ready, issue (k ^ k>>24)*M
        ST_K_SAVE,   // k ready, save it and issue h*M
        ST_H_MIX,    // h = h*M ^ k
        ST_TAIL,     // h = (h ^ tail)*M ready
        ST_FIN_MUL,  // issue (h ^ h>>13)*M
        ST_FIN_OUT,  // h ^= h>>15, load result beat
        ST_ERR_OUT   // load dropped-message beat
    } state_t;

    localparam int unsigned W = mh2_pkg::WORD_W;

    state_t                       state_reg,    state_next;
    logic [W-1:0]                 seed_reg,     seed_next;
    logic [W-1:0]                 hash_reg,     hash_next;
    logic [W-1:0]                 k_reg,        k_next;
    logic                         err_reg,      err_next;
    logic                         last_reg,     last_next;
    logic                         out_valid_reg, out_valid_next;
    logic [W-1:0]                 out_hash_reg, out_hash_next;
    logic                         out_err_reg,  out_err_next;

    logic                         mul_en;
    logic [W-1:0]                 mul_operand;
    logic [W-1:0]                 product;

    logic                         accept;
    logic [W-1:0]                 hash_start;
    logic                         err_start;
    logic                         bad_count;
    logic                         out_free;
    logic [W-1:0]                 fin_hash;

    mh2_mul_unit u_mul (
        .clk     (clk),
        .en      (mul_en),
        .operand (mul_operand),
        .product (product)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;

    // a first beat restarts the hash and clears a pending drop
    assign hash_start = in_ch.first_word ? (seed_reg ^ in_ch.total_length) : hash_reg;
    assign err_start  = in_ch.first_word ? 1'b0 : err_reg;
    assign bad_count  = (in_ch.byte_count > mh2_pkg::FULL_COUNT) ||
                        ((in_ch.byte_count != mh2_pkg::FULL_COUNT) && !in_ch.last_word);

    // result slot is free if empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ch.ready;
    assign fin_hash = product ^ (product >> mh2_pkg::FIN_SHIFT_B);

    always_comb
    begin
        state_next     = state_reg;
        seed_next      = cfg_wr_en ? cfg_wr_data : seed_reg;
        hash_next      = hash_reg;
        k_next         = k_reg;
        err_next       = err_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_hash_next  = out_hash_reg;
        out_err_next   = out_err_reg;
        mul_en         = 1'b0;
        mul_operand    = hash_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    hash_next = hash_start;
                    last_next = in_ch.last_word;
                    err_next  = err_start;
                    if (bad_count || err_start)
                    begin
                        err_next   = 1'b1;
                        state_next = in_ch.last_word ? ST_ERR_OUT : ST_IDLE;
                    end
                    else if (in_ch.byte_count == mh2_pkg::FULL_COUNT)
                    begin
                        mul_en      = 1'b1;
                        mul_operand = in_ch.data_word;
                        state_next  = ST_K_XOR;
                    end
                    else if (in_ch.byte_count == '0)
                    begin
                        // empty tail, straight to finalization
                        state_next = ST_FIN_MUL;
                    end
                    else
                    begin
                        mul_en      = 1'b1;
                        mul_operand = hash_start ^
                                      mh2_pkg::tail_bytes(in_ch.data_word, in_ch.byte_count);
                        state_next  = ST_TAIL;
                    end
                end
            end
            ST_K_XOR:
            begin
                mul_en      = 1'b1;
                mul_operand = product ^ (product >> mh2_pkg::MIX_SHIFT);
                state_next  = ST_K_SAVE;
            end
            ST_K_SAVE:
            begin
                k_next      = product;
                mul_en      = 1'b1;
                mul_operand = hash_reg;
                state_next  = ST_H_MIX;
            end
            ST_H_MIX:
            begin
                hash_next  = product ^ k_reg;
                state_next = last_reg ? ST_FIN_MUL : ST_IDLE;
            end
            ST_TAIL:
            begin
                hash_next  = product;
                state_next = ST_FIN_MUL;
            end
            ST_FIN_MUL:
            begin
                mul_en      = 1'b1;
                mul_operand = hash_reg ^ (hash_reg >> mh2_pkg::FIN_SHIFT_A);
                state_next  = ST_FIN_OUT;
            end
            ST_FIN_OUT:
            begin
                // product holds until the result slot frees up
                if (out_free)
                begin
                    hash_next      = fin_hash;
                    err_next       = 1'b0;
                    out_valid_next = 1'b1;
                    out_hash_next  = fin_hash;
                    out_err_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            ST_ERR_OUT:
            begin
                if (out_free)
                begin
                    err_next       = 1'b0;
                    out_valid_next = 1'b1;
                    out_hash_next  = '0;
                    out_err_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            seed_reg      <= mh2_pkg::SEED_RESET;
            hash_reg      <= '0;
            k_reg         <= '0;
            err_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_hash_reg  <= '0;
            out_err_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seed_reg      <= seed_next;
            hash_reg      <= hash_next;
            k_reg         <= k_next;
            err_reg       <= err_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            out_hash_reg  <= out_hash_next;
            out_err_reg   <= out_err_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.hash_value   = out_hash_reg;
    assign out_ch.length_error = out_err_reg;

endmodule

// ===== hw/rtl/mh2_mul_unit.sv =====
// shared multiplier by the mixing constant, registered product
module mh2_mul_unit (
    input  logic                       clk,
    input  logic                       en,
    input  logic [mh2_pkg::WORD_W-1:0] operand,
    output logic [mh2_pkg::WORD_W-1:0] product
);

    logic [mh2_pkg::WORD_W-1:0] product_reg;
    logic [mh2_pkg::WORD_W-1:0] product_next;

    // low word of the product only
    assign product_next = mh2_pkg::WORD_W'(operand * mh2_pkg::MIX_MUL);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

// ===== hw/rtl/mh2_checker.sv =====
// port-level assertions for the hash engine, bound to the top level
module mh2_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [mh2_pkg::COUNT_W-1:0] in_count,
    input logic                        in_first,
    input logic                        in_last,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [mh2_pkg::WORD_W-1:0]  out_hash,
    input logic                        out_err
);

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_hash) && $stable(out_err))
        else $error("result beat changed while stalled");

    // dropped messages report a zero hash
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_err |-> out_hash == '0)
        else $error("error beat with nonzero hash");

    // a full first word keeps the shared multiplier busy
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_first && in_count == mh2_pkg::FULL_COUNT |=> !in_ready)
        else $error("ready during word mixing");

    // a short or oversized non-last word is dropped at once
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_last && in_count != mh2_pkg::FULL_COUNT |=> in_ready)
        else $error("dropped beat did not return to idle");

endmodule

bind murmur2_hash_engine_top mh2_checker u_mh2_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_count  (in_ch.byte_count),
    .in_first  (in_ch.first_word),
    .in_last   (in_ch.last_word),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_hash  (out_ch.hash_value),
    .out_err   (out_ch.length_error)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the streaming murmurhash2 engine
module tb_top;

    localparam int ITEM_GOAL     = 1650;  // random beats to send
    localparam int PHASE_LEN     = 300;   // random beats between seed changes
    localparam int CALM_TAIL     = 150;   // last beats run without idling
    localparam int SETTLE_CYCLES = 12;    // covers a full word plus finalization
    localparam int DRAIN_CYCLES  = 20;
    localparam int REPORT_LIMIT  = 10;

    // one input beat, field by field as on in_ch
    typedef struct packed {
        logic [mh2_pkg::WORD_W-1:0]  data_word;
        logic [mh2_pkg::COUNT_W-1:0] byte_count;
        logic                        first_word;
        logic                        last_word;
        logic [mh2_pkg::WORD_W-1:0]  total_length;
    } hash_beat_t;

    // one result beat as on out_ch
    typedef struct packed {
        logic [mh2_pkg::WORD_W-1:0] hash_value;
        logic                       length_error;
    } digest_t;

    // directed row: a beat, plus a typed-in result where it is obvious
    typedef struct packed {
        hash_beat_t beat;
        logic       typed;
        digest_t    typed_digest;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [mh2_pkg::WORD_W-1:0] cfg_wr_data;

    mh2_in_if  in_ch ();
    mh2_out_if out_ch ();

    murmur2_hash_engine_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // predictor state: seed register, running hash, drop flag
    logic [mh2_pkg::WORD_W-1:0] seed_shadow;
    logic [mh2_pkg::WORD_W-1:0] chain_hash;
    logic                       chain_dropped;

    digest_t  digests_due[$];   // results still owed by the engine, oldest first
    dir_row_t directed_rows[$];

    int  items_sent;
    int  fail_count;
    bit  calm;            // set near the end: no idling on either side
    bit  sender_steady;   // per-message stretch with no sender gaps

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // all inputs known from time zero; reset asserted until the main sequence releases it
    initial
    begin
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_wr_data        = '0;
        in_ch.valid        = 1'b0;
        in_ch.data_word    = '0;
        in_ch.byte_count   = '0;
        in_ch.first_word   = 1'b0;
        in_ch.last_word    = 1'b0;
        in_ch.total_length = '0;
        out_ch.ready       = 1'b0;
    end

    // hard stop in case the engine hangs
    initial
    begin
        #5_000_000;
        $display("** murmur2_hash_engine_top: FAILED **");
        $finish;
    end

    task automatic note_failure(input string msg);
        begin
            if (fail_count < REPORT_LIMIT)
                $display("[%0t] %s", $realtime, msg);
            fail_count++;
        end
    endtask

    // predicts one accepted beat; returns 1 when it produces a result
    function automatic bit murmur_predict(input hash_beat_t b, output digest_t d);
        logic [mh2_pkg::WORD_W-1:0] k;
        logic [mh2_pkg::WORD_W-1:0] h;
        begin
            d = '0;
            if (b.first_word)
            begin
                chain_hash    = seed_shadow ^ b.total_length;
                chain_dropped = 1'b0;
            end
            // short count before the end, or any count above four, drops the message
            if (b.byte_count > mh2_pkg::FULL_COUNT
                || (b.byte_count < mh2_pkg::FULL_COUNT && !b.last_word))
            begin
                chain_dropped = 1'b1;
            end
            else if (!chain_dropped)
            begin
                if (b.byte_count == mh2_pkg::FULL_COUNT)
                begin
                    k = b.data_word * mh2_pkg::MIX_MUL;
                    k = k ^ (k >> mh2_pkg::MIX_SHIFT);
                    k = k * mh2_pkg::MIX_MUL;
                    chain_hash = (chain_hash * mh2_pkg::MIX_MUL) ^ k;
                end
                else if (b.byte_count != '0)
                begin
                    // tail bytes 1..3 folded in, highest valid byte first
                    h = chain_hash;
                    if (b.byte_count >= 3)
                        h = h ^ (b.data_word & 32'h00ff_0000);
                    if (b.byte_count >= 2)
                        h = h ^ (b.data_word & 32'h0000_ff00);
                    h = h ^ (b.data_word & 32'h0000_00ff);
                    chain_hash = h * mh2_pkg::MIX_MUL;
                end
            end
            if (!b.last_word)
                return 1'b0;
            if (chain_dropped)
            begin
                d.hash_value   = '0;
                d.length_error = 1'b1;
            end
            else
            begin
                h = chain_hash;
                h = h ^ (h >> mh2_pkg::FIN_SHIFT_A);
                h = h * mh2_pkg::MIX_MUL;
                h = h ^ (h >> mh2_pkg::FIN_SHIFT_B);
                chain_hash     = h;
                d.hash_value   = h;
                d.length_error = 1'b0;
            end
            chain_dropped = 1'b0;
            return 1'b1;
        end
    endfunction

    // drives one beat, waits for the handshake, then records what it owes
    task automatic send_beat(input hash_beat_t b, input bit use_typed, input digest_t typed_d);
        digest_t d;
        begin
            if (!calm && !sender_steady && $urandom_range(0, 3) == 0)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            in_ch.valid        <= 1'b1;
            in_ch.data_word    <= b.data_word;
            in_ch.byte_count   <= b.byte_count;
            in_ch.first_word   <= b.first_word;
            in_ch.last_word    <= b.last_word;
            in_ch.total_length <= b.total_length;
            do
                @(posedge clk);
            while (!in_ch.ready);
            items_sent++;
            if (murmur_predict(b, d))
                digests_due.push_back(use_typed ? typed_d : d);
        end
    endtask

    // seed writes only with the engine idle: drained, then settled
    task automatic write_seed(input logic [mh2_pkg::WORD_W-1:0] v);
        begin
            in_ch.valid <= 1'b0;
            while (digests_due.size() != 0)
                @(posedge clk);
            repeat (SETTLE_CYCLES) @(posedge clk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= v;
            @(posedge clk);
            cfg_wr_en   <= 1'b0;
            seed_shadow = v;
        end
    endtask

    // one message: nfull full words, then a last beat; with_first flags beat 0 as first
    // tail_cnt 0..3 is a short last beat, 4 a full last word
    // bad_pos marks the beat that gets an illegal count, -1 for none
    task automatic send_message(input int nfull, input int tail_cnt, input bit with_first,
                                input int bad_pos, input bit wild_len);
        hash_beat_t b;
        int         n_beats;
        int         v;
        begin
            n_beats = nfull + 1;
            for (int i = 0; i < n_beats; i++)
            begin
                b.data_word  = $urandom;
                b.first_word = with_first && (i == 0);
                b.last_word  = (i == n_beats - 1);
                b.byte_count = b.last_word ? mh2_pkg::COUNT_W'(tail_cnt) : mh2_pkg::FULL_COUNT;
                if (i == bad_pos)
                begin
                    // last beat only errors on counts above four
                    if (b.last_word)
                        v = 5 + $urandom_range(0, 2);
                    else
                    begin
                        v = $urandom_range(0, 6);
                        if (v >= 4)
                            v = v + 1;
                    end
                    b.byte_count = mh2_pkg::COUNT_W'(v);
                end
                b.total_length = mh2_pkg::WORD_W'(4 * nfull + tail_cnt);
                if (wild_len || (!b.first_word && $urandom_range(0, 1) == 1))
                    b.total_length = $urandom;
                send_beat(b, 1'b0, '0);
            end
        end
    endtask

    function automatic dir_row_t mk_row(input logic [mh2_pkg::WORD_W-1:0] word, input int count,
                                        input bit first, input bit last,
                                        input logic [mh2_pkg::WORD_W-1:0] length,
                                        input bit typed,
                                        input logic [mh2_pkg::WORD_W-1:0] hash, input bit err);
        dir_row_t r;
        begin
            r.beat.data_word         = word;
            r.beat.byte_count        = mh2_pkg::COUNT_W'(count);
            r.beat.first_word        = first;
            r.beat.last_word         = last;
            r.beat.total_length      = length;
            r.typed                  = typed;
            r.typed_digest.hash_value   = hash;
            r.typed_digest.length_error = err;
            return r;
        end
    endfunction

    // result checker: every accepted result against the oldest one owed
    always @(posedge clk)
    begin
        digest_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (digests_due.size() == 0)
            begin
                note_failure($sformatf("unexpected result hash %h err %0d",
                                       out_ch.hash_value, out_ch.length_error));
            end
            else
            begin
                want = digests_due.pop_front();
                if (out_ch.hash_value !== want.hash_value
                    || out_ch.length_error !== want.length_error)
                    note_failure($sformatf("mismatch: expected hash %h err %0d, got hash %h err %0d",
                                           want.hash_value, want.length_error,
                                           out_ch.hash_value, out_ch.length_error));
            end
        end
    end

    // result side: ready in random bursts broken by random stalls
    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (calm)
            begin
                out_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
                if (!calm)
                begin
                    out_ch.ready <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(posedge clk);
                end
            end
        end
    end

    // main sequence
    initial
    begin
        hash_beat_t b;
        int         pick;
        int         nfull;
        int         phase;
        int         next_phase;

        seed_shadow   = mh2_pkg::SEED_RESET;
        chain_hash    = '0;
        chain_dropped = 1'b0;
        items_sent    = 0;
        fail_count    = 0;
        calm          = 1'b0;
        sender_steady = 1'b0;

        // directed table, run under the reset seed
        // no first beat after reset: hash stays zero, finalizes to zero
        directed_rows.push_back(mk_row(32'h0000_0000, 0, 0, 1, 32'h0, 1, 32'h0, 0));
        directed_rows.push_back(mk_row(32'h0000_0000, 4, 0, 1, 32'hffff_ffff, 0, 0, 0));
        // full word of all ones then an empty tail
        directed_rows.push_back(mk_row(32'hffff_ffff, 4, 1, 0, 32'd4, 0, 0, 0));
        directed_rows.push_back(mk_row(32'hffff_ffff, 0, 0, 1, 32'h0, 0, 0, 0));
        // first and last on one beat, full word and each tail size
        directed_rows.push_back(mk_row(32'h0000_0000, 4, 1, 1, 32'd0, 0, 0, 0));
        directed_rows.push_back(mk_row(32'hffff_ffff, 1, 1, 1, 32'd1, 0, 0, 0));
        directed_rows.push_back(mk_row(32'h1234_5678, 2, 1, 1, 32'd2, 0, 0, 0));
        directed_rows.push_back(mk_row(32'ha5a5_a5a5, 3, 1, 1, 32'd3, 0, 0, 0));
        // zero-byte tail with a length that does not match the bytes sent
        directed_rows.push_back(mk_row(32'hffff_ffff, 0, 1, 1, 32'hffff_ffff, 0, 0, 0));
        // short beat before the end: rest of the message ignored, dropped
        directed_rows.push_back(mk_row(32'h0bad_cafe, 2, 1, 0, 32'd8, 0, 0, 0));
        directed_rows.push_back(mk_row(32'hffff_ffff, 4, 0, 0, 32'h0, 0, 0, 0));
        directed_rows.push_back(mk_row(32'h00ff_00ff, 3, 0, 1, 32'h0, 1, 32'h0, 1));
        // counts above four
        directed_rows.push_back(mk_row(32'h1111_1111, 5, 1, 1, 32'd4, 1, 32'h0, 1));
        directed_rows.push_back(mk_row(32'h2222_2222, 6, 1, 0, 32'd8, 0, 0, 0));
        directed_rows.push_back(mk_row(32'h3333_3333, 7, 0, 1, 32'h0, 1, 32'h0, 1));
        // zero count on a non-last beat
        directed_rows.push_back(mk_row(32'hffff_ffff, 0, 1, 0, 32'd0, 0, 0, 0));
        directed_rows.push_back(mk_row(32'hffff_ffff, 0, 0, 1, 32'd0, 1, 32'h0, 1));
        // sign-bit extremes of data, length given short of the bytes
        directed_rows.push_back(mk_row(32'h8000_0000, 4, 1, 0, 32'd5, 0, 0, 0));
        directed_rows.push_back(mk_row(32'h7fff_ffff, 4, 0, 0, 32'h8000_0000, 0, 0, 0));
        directed_rows.push_back(mk_row(32'h0000_00ff, 1, 0, 1, 32'h0, 0, 0, 0));
        // no first beat: carries on from the last finalized hash
        directed_rows.push_back(mk_row(32'hdead_beef, 4, 0, 1, 32'h0, 0, 0, 0));
        // restart in the middle of a message
        directed_rows.push_back(mk_row(32'h0f0f_0f0f, 4, 0, 0, 32'h0, 0, 0, 0));
        directed_rows.push_back(mk_row(32'hf0f0_f0f0, 4, 1, 0, 32'd6, 0, 0, 0));
        directed_rows.push_back(mk_row(32'hffff_ffff, 2, 0, 1, 32'h0, 0, 0, 0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed,
                      directed_rows[i].typed_digest);

        // random part: seed changes between phases, extremes first
        items_sent = 0;
        phase      = 0;
        next_phase = 0;
        while (items_sent < ITEM_GOAL)
        begin
            if (items_sent >= next_phase)
            begin
                // engine fully drained before each seed change
                if (phase == 0)
                    write_seed(32'hffff_ffff);
                else if (phase == 1)
                    write_seed(32'h0000_0000);
                else
                    write_seed($urandom);
                phase++;
                next_phase = next_phase + PHASE_LEN;
            end
            calm          = (items_sent > ITEM_GOAL - CALM_TAIL);
            sender_steady = ($urandom_range(0, 3) == 0);
            pick          = $urandom_range(0, 99);
            // mostly short messages, now and then a long one
            nfull = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
            if (pick < 72)
            begin
                send_message(nfull, $urandom_range(0, 4), 1'b1, -1, $urandom_range(0, 9) == 0);
            end
            else if (pick < 86)
            begin
                // broken message: one illegal count somewhere in it
                send_message(nfull, $urandom_range(0, 4), 1'b1, $urandom_range(0, nfull), 1'b0);
            end
            else if (pick < 94)
            begin
                // continuation with no first beat
                send_message(nfull % 3, $urandom_range(0, 4), 1'b0, -1, 1'b0);
            end
            else
            begin
                // noise: every field random
                b.data_word    = $urandom;
                b.byte_count   = mh2_pkg::COUNT_W'($urandom_range(0, 7));
                b.first_word   = 1'($urandom_range(0, 1));
                b.last_word    = 1'($urandom_range(0, 1));
                b.total_length = $urandom;
                send_beat(b, 1'b0, '0);
            end
        end

        // back to the reset seed for one last message
        write_seed(mh2_pkg::SEED_RESET);
        send_message(3, 2, 1'b1, -1, 1'b0);

        in_ch.valid <= 1'b0;
        while (digests_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (digests_due.size() != 0)
            note_failure("results still owed at end of run");

        if (fail_count == 0)
            $display("** murmur2_hash_engine_top: PASSED **");
        else
            $display("** murmur2_hash_engine_top: FAILED **");
        $finish;
    end

endmodule
